// File: rtl/box_overlap_push_out_core_macros.svh
`ifndef BOX_OVERLAP_PUSH_OUT_CORE_MACROS_SVH
`define BOX_OVERLAP_PUSH_OUT_CORE_MACROS_SVH

// same-cycle implication
`define BOP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bop assertion failed");

// next-cycle implication
`define BOP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bop assertion failed");

`endif

// File: rtl/bop_pkg.sv
package bop_pkg;

    localparam int COORD_W           = 31;
    localparam int PUSH_W            = 32;
    localparam int NUM_AXES          = 3;
    localparam int NUM_SIDES         = 6;
    localparam int BOX_W             = 2 * NUM_AXES * COORD_W;
    localparam int S_DATA_W          = 192;
    localparam int S_USER_W          = 2;
    localparam int M_DATA_W          = NUM_AXES * PUSH_W;
    localparam int M_USER_W          = 2;
    localparam int DEFAULT_MAX_BOXES = 64;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_ANCHOR = 2'd2,
        OP_QUERY  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef logic [2:0] side_t;

    typedef struct packed {
        logic load_item;
        logic exec;
        logic clear_acc;
        logic rd_en;
        logic finish;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic pipe_busy;
    } stat_t;

    typedef struct packed {
        logic [PUSH_W-1:0] push_z;
        logic [PUSH_W-1:0] push_y;
        logic [PUSH_W-1:0] push_x;
        logic              collided;
        logic              status;
    } res_t;

    function automatic logic signed [PUSH_W-1:0] sext(input logic signed [COORD_W-1:0] v);
        return {v[COORD_W-1], v};
    endfunction

    function automatic logic [COORD_W-1:0] mag(input logic signed [PUSH_W-1:0] v);
        logic [PUSH_W-1:0] n;
        n = -v;
        return v[PUSH_W-1] ? n[COORD_W-1:0] : v[COORD_W-1:0];
    endfunction

endpackage

// File: rtl/bop_ram.sv
module bop_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/bop_ctrl.sv
`include "box_overlap_push_out_core_macros.svh"

module bop_ctrl #(
    parameter int MAX_BOXES = bop_pkg::DEFAULT_MAX_BOXES,
    parameter int AW        = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1,
    parameter int CW        = $clog2(MAX_BOXES + 1)
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  bop_pkg::stat_t stat,
    input  logic [CW-1:0]  count,
    input  logic           out_free,
    output bop_pkg::cmd_t  cmd,
    output logic [AW-1:0]  rd_addr
);

    import bop_pkg::*;

    state_t        state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.clear_acc = 1'b1;
                idx_next      = '0;
                if (stat.op == OP_QUERY)
                begin
                    state_next = (count == '0) ? ST_DONE : ST_SCAN;
                end
                else
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                cmd.rd_en = 1'b1;
                idx_next  = idx_reg + 1'b1;
                if (CW'(idx_reg) + CW'(1) == count)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rd_addr = idx_reg;

    `BOP_ASSERT_IMPL(a_rd_in_range, clk, rst_n, cmd.rd_en, CW'(idx_reg) < count)
    `BOP_ASSERT_IMPL(a_idle_pipe_empty, clk, rst_n, state_reg == ST_IDLE, !stat.pipe_busy)
    `BOP_ASSERT_IMPL(a_finish_drained, clk, rst_n, cmd.finish, !stat.pipe_busy)

endmodule

// File: rtl/bop_dp.sv
`include "box_overlap_push_out_core_macros.svh"

module bop_dp #(
    parameter int MAX_BOXES = bop_pkg::DEFAULT_MAX_BOXES,
    parameter int AW        = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1,
    parameter int CW        = $clog2(MAX_BOXES + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [bop_pkg::S_DATA_W-1:0]    s_tdata,
    input  logic [bop_pkg::S_USER_W-1:0]    s_tuser,
    input  bop_pkg::cmd_t                   cmd,
    input  logic [AW-1:0]                   rd_addr,
    output bop_pkg::stat_t                  stat,
    output logic [CW-1:0]                   count,
    output bop_pkg::res_t                   res
);

    import bop_pkg::*;

    op_t                       op_reg;
    logic signed [COORD_W-1:0] q_lo_reg [NUM_AXES];
    logic signed [COORD_W-1:0] q_hi_reg [NUM_AXES];
    logic signed [COORD_W-1:0] a_lo_reg [NUM_AXES];
    logic signed [COORD_W-1:0] a_hi_reg [NUM_AXES];
    logic [CW-1:0]             count_reg;
    logic                      full;

    logic [BOX_W-1:0]          wdata;
    logic [BOX_W-1:0]          rdata;
    logic                      we;
    logic signed [COORD_W-1:0] b_lo [NUM_AXES];
    logic signed [COORD_W-1:0] b_hi [NUM_AXES];

    logic                      v_r_reg, v_b_reg, v_c_reg, v_d_reg;

    logic signed [PUSH_W-1:0]  d_next [NUM_SIDES];
    logic signed [PUSH_W-1:0]  c_next [NUM_SIDES];
    logic                      hit_next;
    logic signed [PUSH_W-1:0]  d_b_reg [NUM_SIDES];
    logic signed [PUSH_W-1:0]  c_b_reg [NUM_SIDES];
    logic                      hit_b_reg;

    logic [COORD_W-1:0]        g_c_reg [NUM_SIDES];
    logic signed [PUSH_W-1:0]  c_c_reg [NUM_SIDES];
    logic                      hit_c_reg;

    logic [COORD_W-1:0]        m_next [NUM_AXES];
    side_t                     s_next [NUM_AXES];
    logic [COORD_W-1:0]        m_d_reg [NUM_AXES];
    side_t                     s_d_reg [NUM_AXES];
    logic signed [PUSH_W-1:0]  c_d_reg [NUM_SIDES];
    logic                      hit_d_reg;

    logic [COORD_W-1:0]        best;
    side_t                     side;
    logic [1:0]                axis;

    logic                      status_reg;
    logic                      coll_reg;
    logic signed [PUSH_W-1:0]  push_reg [NUM_AXES];

    assign full  = (count_reg == CW'(MAX_BOXES));
    assign we    = cmd.exec && (op_reg == OP_ADD) && !full;
    assign wdata = {q_hi_reg[2], q_hi_reg[1], q_hi_reg[0],
                    q_lo_reg[2], q_lo_reg[1], q_lo_reg[0]};

    bop_ram #(
        .WIDTH (BOX_W),
        .DEPTH (MAX_BOXES),
        .AW    (AW)
    ) u_box_ram (
        .clk   (clk),
        .we    (we),
        .waddr (count_reg[AW-1:0]),
        .wdata (wdata),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            v_r_reg   <= 1'b0;
            v_b_reg   <= 1'b0;
            v_c_reg   <= 1'b0;
            v_d_reg   <= 1'b0;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                a_lo_reg[a] <= '0;
                a_hi_reg[a] <= '0;
            end
        end
        else
        begin
            v_r_reg <= cmd.rd_en;
            v_b_reg <= v_r_reg;
            v_c_reg <= v_b_reg;
            v_d_reg <= v_c_reg;
            if (cmd.exec)
            begin
                case (op_reg)
                    OP_ADD:
                    begin
                        if (!full)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                    OP_CLEAR:
                    begin
                        count_reg <= '0;
                    end
                    OP_ANCHOR:
                    begin
                        for (int a = 0; a < NUM_AXES; a++)
                        begin
                            a_lo_reg[a] <= q_lo_reg[a];
                            a_hi_reg[a] <= q_hi_reg[a];
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // per-box pipeline: ram read, diffs, magnitudes, pair mins, final pick
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            b_lo[a] = rdata[a*COORD_W +: COORD_W];
            b_hi[a] = rdata[(NUM_AXES+a)*COORD_W +: COORD_W];
        end
        hit_next = 1'b1;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            if (q_lo_reg[a] > b_hi[a] || q_hi_reg[a] < b_lo[a])
            begin
                hit_next = 1'b0;
            end
            d_next[2*a]   = sext(a_hi_reg[a]) - sext(b_lo[a]);
            d_next[2*a+1] = sext(b_hi[a]) - sext(a_lo_reg[a]);
            c_next[2*a]   = sext(q_hi_reg[a]) - sext(b_lo[a]);
            c_next[2*a+1] = sext(q_lo_reg[a]) - sext(b_hi[a]);
        end
        for (int p = 0; p < NUM_AXES; p++)
        begin
            if (g_c_reg[2*p+1] < g_c_reg[2*p])
            begin
                m_next[p] = g_c_reg[2*p+1];
                s_next[p] = side_t'(2*p+1);
            end
            else
            begin
                m_next[p] = g_c_reg[2*p];
                s_next[p] = side_t'(2*p);
            end
        end
        best = m_d_reg[0];
        side = s_d_reg[0];
        if (m_d_reg[1] < best)
        begin
            best = m_d_reg[1];
            side = s_d_reg[1];
        end
        if (m_d_reg[2] < best)
        begin
            side = s_d_reg[2];
        end
        axis = side[2:1];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg <= op_t'(s_tuser);
            for (int a = 0; a < NUM_AXES; a++)
            begin
                q_lo_reg[a] <= s_tdata[a*COORD_W +: COORD_W];
                q_hi_reg[a] <= s_tdata[(NUM_AXES+a)*COORD_W +: COORD_W];
            end
        end
        hit_b_reg <= hit_next;
        hit_c_reg <= hit_b_reg;
        hit_d_reg <= hit_c_reg;
        for (int s = 0; s < NUM_SIDES; s++)
        begin
            d_b_reg[s] <= d_next[s];
            c_b_reg[s] <= c_next[s];
            g_c_reg[s] <= mag(d_b_reg[s]);
            c_c_reg[s] <= c_b_reg[s];
            c_d_reg[s] <= c_c_reg[s];
        end
        for (int p = 0; p < NUM_AXES; p++)
        begin
            m_d_reg[p] <= m_next[p];
            s_d_reg[p] <= s_next[p];
        end
        if (cmd.clear_acc)
        begin
            status_reg <= (op_reg == OP_ADD) && full;
            coll_reg   <= 1'b0;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                push_reg[a] <= '0;
            end
        end
        if (v_d_reg && hit_d_reg)
        begin
            coll_reg       <= 1'b1;
            push_reg[axis] <= c_d_reg[side];
        end
    end

    assign stat.op        = op_reg;
    assign stat.pipe_busy = v_r_reg | v_b_reg | v_c_reg | v_d_reg;
    assign count          = count_reg;

    assign res.status   = status_reg;
    assign res.collided = coll_reg;
    assign res.push_x   = push_reg[0];
    assign res.push_y   = push_reg[1];
    assign res.push_z   = push_reg[2];

    `BOP_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(MAX_BOXES))
    `BOP_ASSERT_NEXT(a_full_add_holds, clk, rst_n, cmd.exec && op_reg == OP_ADD && full,
        $stable(count_reg))

endmodule

// File: rtl/bop_out.sv
module bop_out (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  bop_pkg::res_t                res,
    output logic                         free,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [bop_pkg::M_DATA_W-1:0] m_tdata,
    output logic [bop_pkg::M_USER_W-1:0] m_tuser
);

    import bop_pkg::*;

    logic valid_reg, valid_next;
    res_t data_reg;

    assign free       = !valid_reg || m_tready;
    assign valid_next = load ? 1'b1 : (m_tready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {data_reg.push_z, data_reg.push_y, data_reg.push_x};
    assign m_tuser  = {data_reg.collided, data_reg.status};

endmodule

// File: rtl/box_overlap_push_out_core.sv
// Box table with overlap test and push-out query.
// Input stream: one word per operation; tuser carries the op (add box, clear table,
// load anchor box, query moved box), tdata carries the low and high box corners.
// Output stream: exactly one word per input word; tuser carries status (add dropped
// because the table is full) and collided, tdata the push vector (zero unless a query hit).
// Add, clear, anchor load and a query on an empty table pass from accept through the
// exec and done states into the output register.
// A query on N stored boxes reads the box RAM one entry per cycle into a four-stage
// compare pipeline, which drains before the result is out.
// One operation is in flight at a time; the next word is accepted once the current
// one has moved into the output register, so the block takes a new word while the
// previous result still waits on m_tready.
// A stalled receiver holds the output register; work on the next word finishes and
// then waits until the output register is free.
// Reset empties the table, zeroes the anchor box and drops any pending output word.
// Box entries are not cleared: entries past the count are never read.
module box_overlap_push_out_core #(
    parameter int MAX_BOXES = bop_pkg::DEFAULT_MAX_BOXES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // low_x, low_y, low_z, high_x, high_y, high_z (31 bits each), zero pad
    input  logic [bop_pkg::S_DATA_W-1:0] s_tdata,
    // op
    input  logic [bop_pkg::S_USER_W-1:0] s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // push_x, push_y, push_z (32 bits each)
    output logic [bop_pkg::M_DATA_W-1:0] m_tdata,
    // status, collided
    output logic [bop_pkg::M_USER_W-1:0] m_tuser
);

    import bop_pkg::*;

    localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CW = $clog2(MAX_BOXES + 1);

    cmd_t          cmd;
    stat_t         stat;
    logic [CW-1:0] count;
    logic [AW-1:0] rd_addr;
    logic          out_free;
    res_t          res;

    bop_ctrl #(
        .MAX_BOXES (MAX_BOXES),
        .AW        (AW),
        .CW        (CW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .count    (count),
        .out_free (out_free),
        .cmd      (cmd),
        .rd_addr  (rd_addr)
    );

    bop_dp #(
        .MAX_BOXES (MAX_BOXES),
        .AW        (AW),
        .CW        (CW)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .cmd     (cmd),
        .rd_addr (rd_addr),
        .stat    (stat),
        .count   (count),
        .res     (res)
    );

    bop_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (cmd.finish),
        .res      (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// File: tb/sv/tb_box_overlap_push_out_core.sv
`timescale 1ns / 1ps

module tb_box_overlap_push_out_core;
    import bop_pkg::*;

    localparam int TABLE_DEPTH = DEFAULT_MAX_BOXES;
    localparam longint ONE = 64'sd65536;
    localparam longint HALF = 64'sd32768;
    localparam longint MINC = -(64'sd1 <<< 30);
    localparam longint MAXC = (64'sd1 <<< 30) - 1;
    localparam longint NEAR = 64'sd1 <<< 20;

    typedef struct packed {
        logic [NUM_AXES-1:0][COORD_W-1:0] hi;  // x lowest
        logic [NUM_AXES-1:0][COORD_W-1:0] lo;
    } box_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [S_USER_W-1:0] s_tuser = OP_ADD;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [M_USER_W-1:0] m_tuser;

    // shadow of the box table
    box_t   tbl [TABLE_DEPTH];
    int     tbl_count = 0;
    box_t   anchor = '0;

    res_t   results_due[$];
    int     errors = 0;
    int     words_sent = 0;
    int     src_idle_pct = 0;
    int     sink_idle_pct = 0;
    int     hold_req = 0;
    int     hold_left = 0;

    box_overlap_push_out_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #5 clk = ~clk;

    initial
    begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic longint sc(input logic [COORD_W-1:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint absdiff(input longint a, input longint b);
        longint d;
        d = a - b;
        return (d < 0) ? -d : d;
    endfunction

    function automatic box_t make_box(input longint lx, input longint ly, input longint lz,
                                      input longint hx, input longint hy, input longint hz);
        box_t b;
        b.lo[0] = lx[COORD_W-1:0];
        b.lo[1] = ly[COORD_W-1:0];
        b.lo[2] = lz[COORD_W-1:0];
        b.hi[0] = hx[COORD_W-1:0];
        b.hi[1] = hy[COORD_W-1:0];
        b.hi[2] = hz[COORD_W-1:0];
        return b;
    endfunction

    function automatic box_t cube(input longint l, input longint h);
        return make_box(l, l, l, h, h, h);
    endfunction

    // updates the shadow table and returns the word the block should answer with
    function automatic res_t predict_push_out(input op_t op, input box_t q);
        res_t   r;
        longint gap [NUM_SIDES];
        longint push [NUM_AXES];
        longint best;
        int     i, a, s, side;
        bit     hit;
        r = '0;
        for (a = 0; a < NUM_AXES; a++)
            push[a] = 0;
        case (op)
            OP_ADD:
            begin
                if (tbl_count < TABLE_DEPTH)
                begin
                    tbl[tbl_count] = q;
                    tbl_count++;
                end
                else
                    r.status = 1'b1;
            end
            OP_CLEAR:
                tbl_count = 0;
            OP_ANCHOR:
                anchor = q;
            default:
            begin
                for (i = 0; i < tbl_count; i++)
                begin
                    hit = 1'b1;
                    for (a = 0; a < NUM_AXES; a++)
                        if (sc(q.lo[a]) > sc(tbl[i].hi[a]) || sc(q.hi[a]) < sc(tbl[i].lo[a]))
                            hit = 1'b0;
                    if (hit)
                    begin
                        for (a = 0; a < NUM_AXES; a++)
                        begin
                            gap[2*a]   = absdiff(sc(anchor.hi[a]), sc(tbl[i].lo[a]));
                            gap[2*a+1] = absdiff(sc(tbl[i].hi[a]), sc(anchor.lo[a]));
                        end
                        side = 0;
                        best = gap[0];
                        for (s = 1; s < NUM_SIDES; s++)
                            if (gap[s] < best)
                            begin
                                best = gap[s];
                                side = s;
                            end
                        a = side / 2;
                        if (side % 2 == 0)
                            push[a] = sc(q.hi[a]) - sc(tbl[i].lo[a]);
                        else
                            push[a] = sc(q.lo[a]) - sc(tbl[i].hi[a]);
                        r.collided = 1'b1;
                    end
                end
                r.push_x = push[0][PUSH_W-1:0];
                r.push_y = push[1][PUSH_W-1:0];
                r.push_z = push[2][PUSH_W-1:0];
            end
        endcase
        return r;
    endfunction

    function automatic longint rand_coord_wide();
        case ($urandom_range(5))
            0: return MINC;
            1: return MAXC;
            2: return 0;
            3: return -1;
            default: return sc(COORD_W'($urandom()));
        endcase
    endfunction

    function automatic box_t rand_box();
        box_t   b;
        longint l, h, t;
        int     a, mode;
        mode = $urandom_range(99);
        for (a = 0; a < NUM_AXES; a++)
        begin
            if (mode < 70)
            begin
                l = longint'($urandom_range(0, 2 * NEAR)) - NEAR;
                h = l + longint'($urandom_range(0, NEAR / 4));
                if ($urandom_range(19) == 0)
                begin
                    t = l;
                    l = h;
                    h = t;
                end
            end
            else
            begin
                l = rand_coord_wide();
                h = rand_coord_wide();
            end
            b.lo[a] = l[COORD_W-1:0];
            b.hi[a] = h[COORD_W-1:0];
        end
        return b;
    endfunction

    // box close to a stored one, so that queries hit often
    function automatic box_t near_box();
        box_t   b;
        longint v;
        int     i, a;
        if (tbl_count == 0)
            return rand_box();
        i = $urandom_range(tbl_count - 1);
        for (a = 0; a < NUM_AXES; a++)
        begin
            v = sc(tbl[i].lo[a]) + longint'($urandom_range(0, 2 * ONE)) - ONE;
            b.lo[a] = v[COORD_W-1:0];
            v = sc(tbl[i].hi[a]) + longint'($urandom_range(0, 2 * ONE)) - ONE;
            b.hi[a] = v[COORD_W-1:0];
        end
        return b;
    endfunction

    task automatic send_word(input op_t op, input box_t b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_DATA_W - BOX_W){1'b0}}, b};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        results_due.push_back(predict_push_out(op, b));
        words_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (results_due.size() != 0)
            @(posedge clk);
    endtask

    // output side: random stalls plus an occasional long hold-off
    always @(posedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge clk)
    begin
        res_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata, m_tuser};
            if (results_due.size() == 0)
            begin
                errors++;
                $display("%0t: word with nothing expected, actual %h", $time, got);
            end
            else
            begin
                want = results_due.pop_front();
                if (got.status !== want.status)
                begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             got.status);
                end
                if (got.collided !== want.collided)
                begin
                    errors++;
                    $display("%0t: collided expected %0d actual %0d", $time, want.collided,
                             got.collided);
                end
                if (got.push_x !== want.push_x)
                begin
                    errors++;
                    $display("%0t: push_x expected %h actual %h", $time, want.push_x,
                             got.push_x);
                end
                if (got.push_y !== want.push_y)
                begin
                    errors++;
                    $display("%0t: push_y expected %h actual %h", $time, want.push_y,
                             got.push_y);
                end
                if (got.push_z !== want.push_z)
                begin
                    errors++;
                    $display("%0t: push_z expected %h actual %h", $time, want.push_z,
                             got.push_z);
                end
            end
        end
    end

    task automatic test_directed();
        src_idle_pct = 0;
        sink_idle_pct = 0;
        send_word(OP_CLEAR, '1);                    // corners ignored
        send_word(OP_QUERY, cube(-ONE, ONE));       // empty table
        send_word(OP_ADD, cube(MINC, MAXC));
        send_word(OP_ANCHOR, cube(MINC, MINC));
        send_word(OP_QUERY, cube(MINC, MAXC));      // largest positive push
        send_word(OP_ANCHOR, cube(MAXC, MAXC));
        send_word(OP_QUERY, cube(MINC, MAXC));      // largest negative push
        send_word(OP_ANCHOR, cube(MINC, MAXC));     // widest gaps, all tied
        send_word(OP_QUERY, cube(MAXC, MAXC));
        send_word(OP_CLEAR, cube(MINC, MAXC));
        send_word(OP_ADD, cube(0, 2 * ONE));
        send_word(OP_ANCHOR, cube(ONE, ONE));       // six equal gaps, x low side wins
        send_word(OP_QUERY, cube(2 * ONE, 5 * ONE)); // touching faces count
        send_word(OP_QUERY, cube(2 * ONE + 1, 5 * ONE));
        send_word(OP_QUERY, cube(-3 * ONE, 0));     // hit with zero push
        send_word(OP_ADD, cube(ONE, 3 * ONE));
        send_word(OP_QUERY, cube(ONE, 2 * ONE));    // later hit overwrites x
        send_word(OP_ADD, make_box(-5 * ONE, -5 * ONE, -5 * ONE, 5 * ONE, 5 * ONE, ONE));
        send_word(OP_QUERY, cube(HALF, 2 * ONE));   // x and z both set
        send_word(OP_CLEAR, '0);
        send_word(OP_ADD, make_box(4 * ONE, 0, 0, 0, 4 * ONE, 4 * ONE)); // inverted x
        send_word(OP_QUERY, cube(ONE, 2 * ONE));
        send_word(OP_QUERY, make_box(-ONE, ONE, ONE, 5 * ONE, 2 * ONE, 2 * ONE));
        wait_drained();
    endtask

    task automatic test_full_table();
        src_idle_pct = 10;
        sink_idle_pct = 10;
        send_word(OP_CLEAR, rand_box());
        repeat (TABLE_DEPTH + 2)
            send_word(OP_ADD, rand_box());
        send_word(OP_ANCHOR, near_box());
        repeat (3)
            send_word(OP_QUERY, near_box());
        send_word(OP_QUERY, cube(MINC, MAXC));
        send_word(OP_CLEAR, '0);
        send_word(OP_ADD, rand_box());
        wait_drained();
    endtask

    task automatic test_output_hold();
        src_idle_pct = 0;
        sink_idle_pct = 0;
        hold_req = 400;
        repeat (4)
            send_word(OP_ADD, rand_box());
        send_word(OP_ANCHOR, near_box());
        repeat (6)
            send_word(OP_QUERY, near_box());
        wait_drained();
    endtask

    task automatic test_random(input int n_items, input int src_pct, input int sink_pct);
        int start, pick, n_add, n_query;
        src_idle_pct = src_pct;
        sink_idle_pct = sink_pct;
        start = words_sent;
        while (words_sent - start < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
            begin
                if ($urandom_range(1))
                    send_word(OP_CLEAR, rand_box());
                n_add = ($urandom_range(9) == 0) ? $urandom_range(40, 70) : $urandom_range(8);
                repeat (n_add)
                    send_word(OP_ADD, rand_box());
                send_word(OP_ANCHOR, $urandom_range(1) ? near_box() : rand_box());
                n_query = $urandom_range(1, 4);
                repeat (n_query)
                    send_word(OP_QUERY, ($urandom_range(9) < 6) ? near_box() : rand_box());
            end
            else if (pick < 96)
                send_word(op_t'($urandom_range(3)), rand_box());
            else
                wait_drained();
        end
        wait_drained();
    endtask

    initial
    begin
        int k;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_table();
        test_output_hold();
        test_random(300, 18, 45);
        test_random(300, 45, 18);
        test_random(250, 0, 0);
        s_tvalid <= 1'b0;
        for (k = 0; k < 200000 && results_due.size() != 0; k++)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (results_due.size() != 0)
        begin
            errors++;
            $display("%0t: %0d words never arrived", $time, results_due.size());
        end
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
